// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

// ===== sv/mtk_hid_pkg.sv =====
// ---------------------------------------------------------------------------
// mtk_hid_pkg
// Types, codes and key tables of the multi-tap keypad HID encoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtk_hid_pkg;

  localparam int TIME_W    = 32;
  localparam int TIMEOUT_W = 16;
  localparam int KEY_W     = 4;
  localparam int IDX_W     = 3;
  localparam int GROUP_W   = 4;
  localparam int S_DATA_W  = 40;
  localparam int M_DATA_W  = 24;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

  localparam logic CMD_PRESS = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] LAYER_LETTERS = 2'd0;
  localparam logic [1:0] LAYER_NUMBERS = 2'd1;
  localparam logic [1:0] LAYER_NAV     = 2'd2;

  localparam logic [1:0] SHIFT_OFF    = 2'd0;
  localparam logic [1:0] SHIFT_ONCE   = 2'd1;
  localparam logic [1:0] SHIFT_LOCKED = 2'd2;

  localparam logic [7:0] MOD_NONE  = 8'h00;
  localparam logic [7:0] MOD_SHIFT = 8'h02;
  localparam logic [7:0] USE_ENTER = 8'h28;
  localparam logic [7:0] USE_BKSP  = 8'h2A;
  localparam logic [7:0] USE_SPACE = 8'h2C;
  localparam logic [7:0] USE_ZERO  = 8'h27;
  localparam logic [7:0] USE_ONE   = 8'h1E;
  localparam logic [7:0] USE_A     = 8'h04;

  localparam logic [KEY_W-1:0] KEY_BKSP   = 4'd3;
  localparam logic [KEY_W-1:0] KEY_ENTER  = 4'd7;
  localparam logic [KEY_W-1:0] KEY_SHIFT  = 4'd11;
  localparam logic [KEY_W-1:0] KEY_LAYER1 = 4'd12;
  localparam logic [KEY_W-1:0] KEY_SPACE  = 4'd13;
  localparam logic [KEY_W-1:0] KEY_LAYER2 = 4'd14;
  localparam logic [KEY_W-1:0] KEY_NONE   = 4'd15;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TAP,
    OP_STROKE,
    OP_SHIFT,
    OP_LAYER
  } key_op_t;

  typedef struct packed {
    key_op_t            op;
    logic [GROUP_W-1:0] group;
    logic [7:0]         usage;
    logic [1:0]         layer;
  } key_dec_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] modifier;
    logic [7:0] usage;
  } stroke_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] modifier;
    logic [7:0] usage;
    logic       committed;
    logic       last;
  } result_t;

  // Position of a character key within the nine-key block.
  function automatic logic [GROUP_W-1:0] key_group(logic [KEY_W-1:0] key);
    logic [GROUP_W-1:0] g;
    case (key)
      4'd0:    g = 4'd0;
      4'd1:    g = 4'd1;
      4'd2:    g = 4'd2;
      4'd4:    g = 4'd3;
      4'd5:    g = 4'd4;
      4'd6:    g = 4'd5;
      4'd8:    g = 4'd6;
      4'd9:    g = 4'd7;
      4'd10:   g = 4'd8;
      default: g = 4'd0;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] nav_usage(logic [GROUP_W-1:0] g);
    logic [7:0] u;
    case (g)
      4'd0:    u = 8'h29;
      4'd1:    u = 8'h52;
      4'd2:    u = 8'h2B;
      4'd3:    u = 8'h50;
      4'd4:    u = 8'h51;
      4'd5:    u = 8'h4F;
      4'd6:    u = 8'h4A;
      4'd7:    u = 8'h4B;
      default: u = 8'h4E;
    endcase
    return u;
  endfunction

  function automatic key_dec_t key_decode(logic [1:0] layer, logic [KEY_W-1:0] key);
    key_dec_t d;
    d       = '0;
    d.op    = OP_STROKE;
    d.group = key_group(key);
    case (key)
      KEY_BKSP:  d.usage = USE_BKSP;
      KEY_ENTER: d.usage = USE_ENTER;
      KEY_SPACE: d.usage = USE_SPACE;
      KEY_NONE:  d.op    = OP_NONE;
      KEY_SHIFT: begin
        case (layer)
          LAYER_NUMBERS: d.usage = USE_ZERO;
          LAYER_NAV:     d.usage = 8'h4D;
          default:       d.op    = OP_SHIFT;
        endcase
      end
      KEY_LAYER1: begin
        d.op    = OP_LAYER;
        d.layer = (layer == LAYER_NUMBERS || layer == LAYER_NAV) ? LAYER_LETTERS
                                                                  : LAYER_NUMBERS;
      end
      KEY_LAYER2: begin
        d.op    = OP_LAYER;
        d.layer = (layer == LAYER_NAV) ? LAYER_NUMBERS : LAYER_NAV;
      end
      default: begin
        case (layer)
          LAYER_NUMBERS: d.usage = USE_ONE + {4'd0, d.group};
          LAYER_NAV:     d.usage = nav_usage(d.group);
          default:       d.op    = OP_TAP;
        endcase
      end
    endcase
    return d;
  endfunction

  function automatic logic [IDX_W-1:0] tap_len(logic [GROUP_W-1:0] g);
    logic [IDX_W-1:0] n;
    case (g)
      4'd0:       n = 3'd7;
      4'd6, 4'd8: n = 3'd4;
      default:    n = 3'd3;
    endcase
    return n;
  endfunction

  function automatic logic [4:0] letter_base(logic [GROUP_W-1:0] g);
    logic [4:0] b;
    case (g)
      4'd1:    b = 5'd0;
      4'd2:    b = 5'd3;
      4'd3:    b = 5'd6;
      4'd4:    b = 5'd9;
      4'd5:    b = 5'd12;
      4'd6:    b = 5'd15;
      4'd7:    b = 5'd19;
      default: b = 5'd22;
    endcase
    return b;
  endfunction

  function automatic stroke_t tap_stroke(logic [GROUP_W-1:0] g, logic [IDX_W-1:0] idx,
                                         logic upper);
    stroke_t s;
    s = '0;
    if (g == 4'd0 || g > 4'd8) begin
      s.valid = 1'b1;
      case (idx)
        3'd0:    s.usage = 8'h37;
        3'd1:    s.usage = 8'h36;
        3'd2:    begin s.modifier = MOD_SHIFT; s.usage = 8'h38; end
        3'd3:    begin s.modifier = MOD_SHIFT; s.usage = 8'h1E; end
        3'd4:    s.usage = 8'h34;
        3'd5:    s.usage = 8'h2D;
        3'd6:    begin s.modifier = MOD_SHIFT; s.usage = 8'h1F; end
        default: s.valid = 1'b0;
      endcase
    end else begin
      s.valid    = idx < tap_len(g);
      s.modifier = upper ? MOD_SHIFT : MOD_NONE;
      s.usage    = USE_A + {3'd0, letter_base(g)} + {5'd0, idx};
    end
    return s;
  endfunction

endpackage

// ===== sv/multitap_keypad_hid_encoder.sv =====
// ---------------------------------------------------------------------------
// multitap_keypad_hid_encoder
// Multi-tap keypad with letter, number and navigation layers; turns key
// press and tick requests into HID keystroke and tick status results.
// ---------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   tuser cmd; tdata key_index, now_ms
//  m_*      out  m_tvalid/m_tready   tuser kind; tdata modifier, usage,
//                                    committed; tlast last
//  cfg_*    in   cfg_wr_en           cfg_wr_data multitap_timeout_ms
//
//  One request per cycle while s_tready is high: a request is registered,
//  then decoded against the keypad state, and its zero, one or two results
//  enter a four-entry result queue; the output port drains one result a
//  cycle while m_tready is high, so two-result requests lower the sustained
//  request rate. First results pass the input register and the queue.
//  rst clears layer, shift, pending key, timeout (1000 ms) and the queue.
//  s_tready drops only while a request waits and the queue holds three or more.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module multitap_keypad_hid_encoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [3:0] key_index, [35:4] now_ms, [39:36] zero
  input  logic [mtk_hid_pkg::S_DATA_W-1:0]    s_tdata,
  // [0] cmd
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [7:0] modifier, [15:8] usage, [16] committed, [23:17] zero
  output logic [mtk_hid_pkg::M_DATA_W-1:0]    m_tdata,
  // [0] kind
  output logic                                m_tuser,
  output logic                                m_tlast,
  input  logic                                cfg_wr_en,
  input  logic [mtk_hid_pkg::TIMEOUT_W-1:0]   cfg_wr_data
);
  import mtk_hid_pkg::*;

  localparam int QDEPTH = 4;

  logic [TIMEOUT_W-1:0] timeout;

  logic                 in_valid;
  logic                 in_cmd;
  logic [KEY_W-1:0]     in_key;
  logic [TIME_W-1:0]    in_now;

  logic [1:0]           active_layer, active_layer_next;
  logic [1:0]           shift_mode, shift_mode_next;
  logic                 pending_valid, pending_valid_next;
  logic [KEY_W-1:0]     pending_key, pending_key_next;
  logic [IDX_W-1:0]     pending_idx, pending_idx_next;
  logic                 pending_upper, pending_upper_next;
  logic [TIME_W-1:0]    pending_time, pending_time_next;

  result_t              q [QDEPTH];
  result_t              q_next [QDEPTH];
  logic [2:0]           cnt, cnt_next, base;

  logic                 fire, pop, expired, is_repeat;
  logic [TIME_W-1:0]    elapsed;
  key_dec_t             dec;
  stroke_t              st;
  result_t              r0, r1;
  logic [1:0]           n_res;

  assign s_tready = !in_valid || (cnt <= 3'd2);
  assign fire     = in_valid && (cnt <= 3'd2);
  assign m_tvalid = cnt != 3'd0;
  assign pop      = m_tvalid && m_tready;
  assign m_tuser  = q[0].kind;
  assign m_tlast  = q[0].last;
  assign m_tdata  = {7'd0, q[0].committed, q[0].usage, q[0].modifier};

  assign elapsed  = in_now - pending_time;
  assign expired  = elapsed >= {{(TIME_W-TIMEOUT_W){1'b0}}, timeout};
  assign dec      = key_decode(active_layer, in_key);
  assign is_repeat = pending_valid && (pending_key == in_key) && !expired;

  always_comb begin
    active_layer_next  = active_layer;
    shift_mode_next    = shift_mode;
    pending_valid_next = pending_valid;
    pending_key_next   = pending_key;
    pending_idx_next   = pending_idx;
    pending_upper_next = pending_upper;
    pending_time_next  = pending_time;
    r0    = '0;
    r1    = '0;
    n_res = 2'd0;
    st    = '0;
    if (in_cmd == CMD_TICK) begin
      r0.kind      = KIND_TICK;
      r0.committed = pending_valid && expired;
      r0.last      = 1'b1;
      n_res        = 2'd1;
      if (pending_valid && expired) begin
        pending_valid_next = 1'b0;
        pending_idx_next   = '0;
      end
    end else begin
      case (dec.op)
        OP_TAP: begin
          if (is_repeat) begin
            pending_idx_next = (pending_idx + 3'd1 == tap_len(dec.group)) ? '0
                                                                         : pending_idx + 3'd1;
          end else begin
            pending_valid_next = 1'b1;
            pending_key_next   = in_key;
            pending_idx_next   = '0;
            pending_upper_next = shift_mode != SHIFT_OFF;
            if (shift_mode == SHIFT_ONCE) shift_mode_next = SHIFT_OFF;
          end
          pending_time_next = in_now;
          st = tap_stroke(dec.group, pending_idx_next, pending_upper_next);
          if (is_repeat) begin
            r0.kind     = KIND_KEY;
            r0.usage    = USE_BKSP;
            r0.last     = !st.valid;
            r1.kind     = KIND_KEY;
            r1.modifier = st.modifier;
            r1.usage    = st.usage;
            r1.last     = 1'b1;
            n_res       = st.valid ? 2'd2 : 2'd1;
          end else begin
            r0.kind     = KIND_KEY;
            r0.modifier = st.modifier;
            r0.usage    = st.usage;
            r0.last     = 1'b1;
            n_res       = st.valid ? 2'd1 : 2'd0;
          end
        end
        OP_STROKE: begin
          pending_valid_next = 1'b0;
          pending_idx_next   = '0;
          r0.kind  = KIND_KEY;
          r0.usage = dec.usage;
          r0.last  = 1'b1;
          n_res    = 2'd1;
        end
        OP_SHIFT: begin
          pending_valid_next = 1'b0;
          pending_idx_next   = '0;
          case (shift_mode)
            SHIFT_OFF:  shift_mode_next = SHIFT_ONCE;
            SHIFT_ONCE: shift_mode_next = SHIFT_LOCKED;
            default:    shift_mode_next = SHIFT_OFF;
          endcase
        end
        OP_LAYER: begin
          pending_valid_next = 1'b0;
          pending_idx_next   = '0;
          active_layer_next  = dec.layer;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    base = cnt - {2'd0, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      q_next[i] = q[i];
    end
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_next[i] = q[i+1];
      end
    end
    cnt_next = base;
    if (fire) begin
      if (n_res != 2'd0) q_next[base[1:0]] = r0;
      if (n_res == 2'd2) q_next[base[1:0] + 2'd1] = r1;
      cnt_next = base + {1'b0, n_res};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q[i] <= q_next[i];
    end
    if (s_tvalid && s_tready) begin
      in_cmd <= s_tuser;
      in_key <= s_tdata[KEY_W-1:0];
      in_now <= s_tdata[KEY_W +: TIME_W];
    end
    if (rst) begin
      timeout       <= TIMEOUT_RESET;
      in_valid      <= 1'b0;
      cnt           <= '0;
      active_layer  <= LAYER_LETTERS;
      shift_mode    <= SHIFT_OFF;
      pending_valid <= 1'b0;
      pending_key   <= '0;
      pending_idx   <= '0;
      pending_upper <= 1'b0;
      pending_time  <= '0;
    end else begin
      if (cfg_wr_en) timeout <= cfg_wr_data;
      if (s_tready) in_valid <= s_tvalid;
      cnt <= cnt_next;
      if (fire) begin
        active_layer  <= active_layer_next;
        shift_mode    <= shift_mode_next;
        pending_valid <= pending_valid_next;
        pending_key   <= pending_key_next;
        pending_idx   <= pending_idx_next;
        pending_upper <= pending_upper_next;
        pending_time  <= pending_time_next;
      end
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEVER(a_queue_bound, cnt > 3'd4, "result queue overflow")
  `ASSERT_CLK(a_tick_last, (m_tvalid && m_tuser == KIND_TICK) |-> (m_tlast && m_tdata[15:8] == 8'd0), "tick result malformed")
  `ASSERT_CLK(a_pending_letters, pending_valid |-> (active_layer == LAYER_LETTERS), "pending key outside letter layer")
  `ASSERT_CLK(a_stall_cause, (!s_tready) |-> (in_valid && cnt >= 3'd3), "input stalled without full queue")

endmodule
